// ===== src/rgbcie_pkg.sv =====
`default_nettype none

package rgbcie_pkg;

    // field widths
    localparam int PIX_W = 8;
    localparam int CHR_W = 8;

    // tristimulus arithmetic
    localparam int SUM_W   = 19;              // weighted sum, at most 300135
    localparam int TRI_W   = 9;               // X, Y, Z after scaling, at most 300
    localparam int RECIP_W = 11;
    localparam int PROD_W  = SUM_W + RECIP_W; // sum times reciprocal
    localparam int RECIP_SHIFT = 20;
    localparam int Q0_W    = PROD_W - RECIP_SHIFT;
    localparam int SCALE_W = 10;
    localparam int BACK_W  = Q0_W + SCALE_W;

    // coefficients in thousandths
    localparam int COEF_XR = 607;
    localparam int COEF_XG = 174;
    localparam int COEF_XB = 200;
    localparam int COEF_YR = 299;
    localparam int COEF_YG = 587;
    localparam int COEF_YB = 114;
    localparam int COEF_ZG = 66;
    localparam int COEF_ZB = 1111;

    // ceil(2^20 / 1000): estimate is exact or one too high
    localparam int RECIP      = 1049;
    localparam int COEF_SCALE = 1000;

    // chromaticity division
    localparam int CHROMA_SHIFT  = 8;                  // times 256
    localparam int DEN_W         = 10;                 // X+Y+Z, at most 805
    localparam int QUO_W         = 9;                  // quotient, at most 256
    localparam int REM_W         = TRI_W + CHROMA_SHIFT;
    localparam int CMP_W         = DEN_W + QUO_W - 1;
    localparam int DIV_BITS      = 3;                  // quotient bits per stage
    localparam int DIV_STAGES    = QUO_W / DIV_BITS;
    localparam int NUM_CH        = 3;                  // X, Y, Z lanes
    localparam int NUM_DIV       = 2;                  // x and y lanes

    typedef struct packed {
        logic vld;
        logic last;
    } side_t;

    typedef struct packed {
        side_t            ctl;
        logic [TRI_W-1:0] x;
        logic [TRI_W-1:0] y;
        logic [TRI_W-1:0] z;
    } tri_word_t;

endpackage

`default_nettype wire

// ===== src/rgbcie_tristim.sv =====
`default_nettype none

module rgbcie_tristim
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire rgbcie_pkg::side_t                ctl_in,
    input  wire logic [rgbcie_pkg::PIX_W-1:0]     red,
    input  wire logic [rgbcie_pkg::PIX_W-1:0]     green,
    input  wire logic [rgbcie_pkg::PIX_W-1:0]     blue,
    output rgbcie_pkg::tri_word_t                 tri_out
);

    localparam int SUM_W  = rgbcie_pkg::SUM_W;
    localparam int PROD_W = rgbcie_pkg::PROD_W;
    localparam int Q0_W   = rgbcie_pkg::Q0_W;
    localparam int BACK_W = rgbcie_pkg::BACK_W;
    localparam int TRI_W  = rgbcie_pkg::TRI_W;
    localparam int NCH    = rgbcie_pkg::NUM_CH;

    rgbcie_pkg::side_t ctl1_reg;
    rgbcie_pkg::side_t ctl2_reg;
    rgbcie_pkg::side_t ctl3_reg;

    logic [SUM_W-1:0]  sum_reg  [NCH];
    logic [SUM_W-1:0]  sum_next [NCH];
    logic [SUM_W-1:0]  sum2_reg [NCH];
    logic [Q0_W-1:0]   q0_reg   [NCH];
    logic [Q0_W-1:0]   q0_next  [NCH];
    logic [TRI_W-1:0]  tri_reg  [NCH];
    logic [TRI_W-1:0]  tri_next [NCH];
    logic [PROD_W-1:0] prod     [NCH];
    logic [BACK_W-1:0] back     [NCH];
    logic              over     [NCH];

    // stage 1: weighted sums
    always_comb
    begin
        sum_next[0] = SUM_W'(red) * SUM_W'(rgbcie_pkg::COEF_XR)
                    + SUM_W'(green) * SUM_W'(rgbcie_pkg::COEF_XG)
                    + SUM_W'(blue) * SUM_W'(rgbcie_pkg::COEF_XB);
        sum_next[1] = SUM_W'(red) * SUM_W'(rgbcie_pkg::COEF_YR)
                    + SUM_W'(green) * SUM_W'(rgbcie_pkg::COEF_YG)
                    + SUM_W'(blue) * SUM_W'(rgbcie_pkg::COEF_YB);
        sum_next[2] = SUM_W'(green) * SUM_W'(rgbcie_pkg::COEF_ZG)
                    + SUM_W'(blue) * SUM_W'(rgbcie_pkg::COEF_ZB);
    end

    // stage 2: reciprocal estimate, stage 3: one-step correction
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            prod[c]     = PROD_W'(sum_reg[c]) * PROD_W'(rgbcie_pkg::RECIP);
            q0_next[c]  = prod[c][PROD_W-1:rgbcie_pkg::RECIP_SHIFT];
            back[c]     = BACK_W'(q0_reg[c]) * BACK_W'(rgbcie_pkg::COEF_SCALE);
            over[c]     = back[c] > BACK_W'(sum2_reg[c]);
            tri_next[c] = TRI_W'(q0_reg[c] - Q0_W'(over[c]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                sum_reg[c]  <= sum_next[c];
                sum2_reg[c] <= sum_reg[c];
                q0_reg[c]   <= q0_next[c];
                tri_reg[c]  <= tri_next[c];
            end
        end
    end

    assign tri_out.ctl = ctl3_reg;
    assign tri_out.x   = tri_reg[0];
    assign tri_out.y   = tri_reg[1];
    assign tri_out.z   = tri_reg[2];

endmodule

`default_nettype wire

// ===== src/rgbcie_divide.sv =====
`default_nettype none

module rgbcie_divide
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire rgbcie_pkg::tri_word_t         tri_in,
    output logic [rgbcie_pkg::CHR_W-1:0]       chroma_x,
    output logic [rgbcie_pkg::CHR_W-1:0]       chroma_y,
    output logic                               defined,
    output rgbcie_pkg::side_t                  ctl_out
);

    localparam int DEN_W  = rgbcie_pkg::DEN_W;
    localparam int QUO_W  = rgbcie_pkg::QUO_W;
    localparam int REM_W  = rgbcie_pkg::REM_W;
    localparam int CMP_W  = rgbcie_pkg::CMP_W;
    localparam int NST    = rgbcie_pkg::DIV_STAGES;
    localparam int NBIT   = rgbcie_pkg::DIV_BITS;
    localparam int NDIV   = rgbcie_pkg::NUM_DIV;
    localparam int SH     = rgbcie_pkg::CHROMA_SHIFT;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    // restoring division, NBIT quotient bits from bit top downward
    function automatic div_lane_t div_steps(div_lane_t lane_in, logic [DEN_W-1:0] den,
                                            int top);
        div_lane_t        lane;
        logic [CMP_W-1:0] shifted;
        lane = lane_in;
        for (int k = 0; k < NBIT; k++)
        begin
            shifted = CMP_W'(den) << (top - k);
            if (CMP_W'(lane.rem) >= shifted)
            begin
                lane.rem            = lane.rem - shifted[REM_W-1:0];
                lane.quo[top - k]   = 1'b1;
            end
        end
        return lane;
    endfunction

    rgbcie_pkg::side_t ctl_reg [NST+1];
    logic              def_reg [NST+1];
    logic [DEN_W-1:0]  den_reg [NST];
    div_lane_t         lane_reg  [NST+1][NDIV];
    div_lane_t         lane_next [NST+1][NDIV];
    logic [DEN_W-1:0]  den_next;
    logic              def_next;

    // stage 0: sum and numerators; a black pixel divides 0 by all-ones
    always_comb
    begin
        den_next = DEN_W'(tri_in.x) + DEN_W'(tri_in.y) + DEN_W'(tri_in.z);
        def_next = den_next != '0;
        if (!def_next)
        begin
            den_next = '1;
        end
        lane_next[0][0].rem = REM_W'({tri_in.x, SH'(0)});
        lane_next[0][0].quo = '0;
        lane_next[0][1].rem = REM_W'({tri_in.y, SH'(0)});
        lane_next[0][1].quo = '0;
    end

    for (genvar s = 1; s <= NST; s++)
    begin : g_stage
        always_comb
        begin
            for (int l = 0; l < NDIV; l++)
            begin
                lane_next[s][l] = div_steps(lane_reg[s-1][l], den_reg[s-1],
                                            QUO_W - 1 - NBIT * (s - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NST; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= tri_in.ctl;
            for (int s = 1; s <= NST; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            def_reg[0] <= def_next;
            den_reg[0] <= den_next;
            for (int s = 1; s <= NST; s++)
            begin
                def_reg[s] <= def_reg[s-1];
            end
            for (int s = 1; s < NST; s++)
            begin
                den_reg[s] <= den_reg[s-1];
            end
            for (int s = 0; s <= NST; s++)
            begin
                for (int l = 0; l < NDIV; l++)
                begin
                    lane_reg[s][l] <= lane_next[s][l];
                end
            end
        end
    end

    // quotient of 256 wraps to 0 in the 8-bit field
    assign chroma_x = lane_reg[NST][0].quo[rgbcie_pkg::CHR_W-1:0];
    assign chroma_y = lane_reg[NST][1].quo[rgbcie_pkg::CHR_W-1:0];
    assign defined  = def_reg[NST];
    assign ctl_out  = ctl_reg[NST];

endmodule

`default_nettype wire

// ===== src/rgb_to_cie_chromaticity.sv =====
// channel  | handshake                    | payload
// ---------+------------------------------+------------------------------------
// pixel    | pixel_valid / pixel_stall    | red, green, blue, end_of_frame
// chroma   | chroma_valid / chroma_stall  | chroma_x, chroma_y, defined, last_out
//
// one pixel per cycle sustained while no chroma word is stalled; pipeline from
// accept to chroma word: 3 tristimulus stages, 1 sum stage, 3 divider stages
// rst_n clears all valid bits and the input skid register, payload is not reset
// a stalled chroma word freezes the whole pipeline; the skid register takes the
// pixel offered in that cycle so pixel_stall is a plain register output
`default_nettype none

module rgb_to_cie_chromaticity
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pixel_valid,
    output logic                               pixel_stall,
    input  wire logic [rgbcie_pkg::PIX_W-1:0]  red,
    input  wire logic [rgbcie_pkg::PIX_W-1:0]  green,
    input  wire logic [rgbcie_pkg::PIX_W-1:0]  blue,
    input  wire logic                          end_of_frame,
    output logic                               chroma_valid,
    input  wire logic                          chroma_stall,
    output logic [rgbcie_pkg::CHR_W-1:0]       chroma_x,
    output logic [rgbcie_pkg::CHR_W-1:0]       chroma_y,
    output logic                               defined,
    output logic                               last_out
);

    localparam int PIX_W = rgbcie_pkg::PIX_W;

    // skid register on the input side
    logic              skid_full_reg;
    logic              skid_full_next;
    logic [PIX_W-1:0]  skid_red_reg;
    logic [PIX_W-1:0]  skid_green_reg;
    logic [PIX_W-1:0]  skid_blue_reg;
    logic              skid_last_reg;

    // pipeline advance: everything moves unless the output word is held
    logic              en;

    rgbcie_pkg::side_t     front_ctl;
    logic [PIX_W-1:0]      front_red;
    logic [PIX_W-1:0]      front_green;
    logic [PIX_W-1:0]      front_blue;
    rgbcie_pkg::tri_word_t tri_word;
    rgbcie_pkg::side_t     out_ctl;

    assign en = !(out_ctl.vld && chroma_stall);

    // front of pipe takes the skid word first, otherwise the live pixel
    always_comb
    begin
        if (skid_full_reg)
        begin
            front_ctl.vld  = 1'b1;
            front_ctl.last = skid_last_reg;
            front_red      = skid_red_reg;
            front_green    = skid_green_reg;
            front_blue     = skid_blue_reg;
        end
        else
        begin
            front_ctl.vld  = pixel_valid;
            front_ctl.last = end_of_frame;
            front_red      = red;
            front_green    = green;
            front_blue     = blue;
        end
    end

    always_comb
    begin
        if (skid_full_reg)
        begin
            skid_full_next = !en;
        end
        else
        begin
            skid_full_next = pixel_valid && !en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    // capture a pixel accepted while the pipeline is frozen
    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && pixel_valid && !en)
        begin
            skid_red_reg   <= red;
            skid_green_reg <= green;
            skid_blue_reg  <= blue;
            skid_last_reg  <= end_of_frame;
        end
    end

    assign pixel_stall = skid_full_reg;

    rgbcie_tristim u_tristim
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (front_ctl),
        .red     (front_red),
        .green   (front_green),
        .blue    (front_blue),
        .tri_out (tri_word)
    );

    // last divider stage doubles as the output register
    rgbcie_divide u_divide
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tri_in   (tri_word),
        .chroma_x (chroma_x),
        .chroma_y (chroma_y),
        .defined  (defined),
        .ctl_out  (out_ctl)
    );

    assign chroma_valid = out_ctl.vld;
    assign last_out     = out_ctl.last;

endmodule

`default_nettype wire

// ===== src/rgbcie_checker.sv =====
`default_nettype none

module rgbcie_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pixel_valid,
    input wire logic                          pixel_stall,
    input wire logic                          chroma_valid,
    input wire logic                          chroma_stall,
    input wire logic [rgbcie_pkg::CHR_W-1:0]  chroma_x,
    input wire logic [rgbcie_pkg::CHR_W-1:0]  chroma_y,
    input wire logic                          defined,
    input wire logic                          last_out
);

    // held word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chroma_valid && chroma_stall |=> chroma_valid && $stable(chroma_x)
            && $stable(chroma_y) && $stable(defined) && $stable(last_out))
        else $error("chroma word changed while stalled");

    // input only backs up after the output side held a word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_stall) |-> $past(chroma_valid && chroma_stall && pixel_valid))
        else $error("pixel_stall rose without output backpressure");

    // black pixel gives zero coordinates
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        chroma_valid && !defined |-> chroma_x == '0 && chroma_y == '0)
        else $error("undefined word carries nonzero coordinates");

    // x + y never exceeds full scale
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chroma_valid |-> ({1'b0, chroma_x} + {1'b0, chroma_y}) <= 9'd256)
        else $error("chromaticity sum above full scale");

endmodule

bind rgb_to_cie_chromaticity rgbcie_checker u_rgbcie_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .chroma_valid (chroma_valid),
    .chroma_stall (chroma_stall),
    .chroma_x     (chroma_x),
    .chroma_y     (chroma_y),
    .defined      (defined),
    .last_out     (last_out)
);

`default_nettype wire

// ===== test/tb_rgb_to_cie_chromaticity.sv =====
`timescale 1ns / 100ps

module tb_rgb_to_cie_chromaticity;

    localparam int PIX_W = rgbcie_pkg::PIX_W;
    localparam int CHR_W = rgbcie_pkg::CHR_W;

    // one expected chroma word, field for field as the block presents it
    typedef struct {
        logic [CHR_W-1:0] x;
        logic [CHR_W-1:0] y;
        logic             def;
        logic             last;
    } chroma_word_t;

    // pipeline is 7 deep; tail wait after the last word, to catch stray words
    localparam int TAIL_CYCLES = 30;

    logic             clk;
    logic             rst_n;
    logic             pixel_valid;
    logic             pixel_stall;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             end_of_frame;
    logic             chroma_valid;
    logic             chroma_stall;
    logic [CHR_W-1:0] chroma_x;
    logic [CHR_W-1:0] chroma_y;
    logic             defined;
    logic             last_out;

    // chroma words owed by the block, oldest first
    chroma_word_t pending_chroma[$];

    int mismatches;
    int words_checked;
    int pixels_sent;
    int black_pixels;
    int wrapped_quotients;
    int frame_ends;

    // idling switches for the pixel sender and the chroma receiver
    bit sender_idles;
    bit receiver_stalls;
    int stall_left;

    rgb_to_cie_chromaticity dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .end_of_frame (end_of_frame),
        .chroma_valid (chroma_valid),
        .chroma_stall (chroma_stall),
        .chroma_x     (chroma_x),
        .chroma_y     (chroma_y),
        .defined      (defined),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // expected chroma word for one pixel
    // tristimulus sums use thousandths and truncate on the divide by 1000,
    // then x and y are 256 * part / total, truncated and cut to 8 bits
    function automatic chroma_word_t predict_chroma(input logic [PIX_W-1:0] r,
                                                    input logic [PIX_W-1:0] g,
                                                    input logic [PIX_W-1:0] b,
                                                    input logic             eof);
        int unsigned  tri_x;
        int unsigned  tri_y;
        int unsigned  tri_z;
        int unsigned  total;
        int unsigned  quo_x;
        int unsigned  quo_y;
        chroma_word_t w;
        tri_x = (607 * r + 174 * g + 200 * b) / 1000;
        tri_y = (299 * r + 587 * g + 114 * b) / 1000;
        tri_z = (66 * g + 1111 * b) / 1000;
        total = tri_x + tri_y + tri_z;
        w.last = eof;
        if (total == 0)
        begin
            // black after truncation: no divide, zero coordinates
            w.x   = '0;
            w.y   = '0;
            w.def = 1'b0;
            black_pixels++;
        end
        else
        begin
            quo_x = (256 * tri_x) / total;
            quo_y = (256 * tri_y) / total;
            // a full-scale quotient of 256 wraps to 0 in the 8-bit field
            if (quo_x == 256 || quo_y == 256)
                wrapped_quotients++;
            w.x   = quo_x[CHR_W-1:0];
            w.y   = quo_y[CHR_W-1:0];
            w.def = 1'b1;
        end
        return w;
    endfunction

    // idle length: mostly none, sometimes short, now and then long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // offer one pixel word and hold it until the block takes it
    task automatic send_pixel(input logic [PIX_W-1:0] r,
                              input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b,
                              input logic             eof);
        int gap;
        gap = sender_idles ? idle_length() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid  <= 1'b1;
        red          <= r;
        green        <= g;
        blue         <= b;
        end_of_frame <= eof;
        do
            @(posedge clk);
        while (pixel_stall);
        pending_chroma.push_back(predict_chroma(r, g, b, eof));
        pixels_sent++;
        if (eof)
            frame_ends++;
    endtask

    // random pixel; some draws stay near black so truncation to zero and
    // the full-scale wrap come up often, some light a single channel
    task automatic send_random_pixel();
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic             eof;
        int               shape;
        shape = $urandom_range(0, 7);
        r     = PIX_W'($urandom_range(0, 255));
        g     = PIX_W'($urandom_range(0, 255));
        b     = PIX_W'($urandom_range(0, 255));
        if (shape == 0)
        begin
            r = PIX_W'($urandom_range(0, 4));
            g = PIX_W'($urandom_range(0, 4));
            b = PIX_W'($urandom_range(0, 4));
        end
        else if (shape == 1)
        begin
            case ($urandom_range(0, 2))
                0:       begin g = '0; b = '0; end
                1:       begin r = '0; b = '0; end
                default: begin r = '0; g = '0; end
            endcase
        end
        eof = ($urandom_range(0, 15) == 0);
        send_pixel(r, g, b, eof);
    endtask

    // stop offering pixels until every owed chroma word has come back
    task automatic wait_drained();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_chroma.size() != 0)
            @(posedge clk);
    endtask

    // corners of the fields and the named special cases
    task automatic test_directed_pixels();
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);  // black
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);  // full white
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0);  // truncates to black
        send_pixel(8'd0,   8'd0,   8'd1,   1'b0);  // only Z survives
        send_pixel(8'd1,   8'd1,   8'd1,   1'b0);
        send_pixel(8'd2,   8'd0,   8'd0,   1'b0);  // x quotient wraps
        send_pixel(8'd0,   8'd2,   8'd0,   1'b1);  // y quotient wraps
        send_pixel(8'd170, 8'd85,  8'd170, 1'b0);
        send_pixel(8'd85,  8'd170, 8'd85,  1'b1);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b1);
        send_pixel(8'd128, 8'd64,  8'd32,  1'b0);
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count)
            send_random_pixel();
    endtask

    // sender holds off until the pipe is empty, then restarts
    task automatic test_drain_pause();
        repeat (50)
            send_random_pixel();
        wait_drained();
        repeat (50)
            send_random_pixel();
    endtask

    // full rate, then back pressure only, then starved input only
    task automatic test_back_to_back();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        repeat (200)
            send_random_pixel();
        receiver_stalls = 1'b1;
        repeat (150)
            send_random_pixel();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b0;
        repeat (150)
            send_random_pixel();
        receiver_stalls = 1'b1;
    endtask

    // chroma receiver: stall runs of random length, changed on the falling edge
    always @(negedge clk)
    begin
        if (stall_left == 0 && receiver_stalls && rst_n)
            stall_left = idle_length();
        if (stall_left > 0)
        begin
            chroma_stall <= 1'b1;
            stall_left--;
        end
        else
            chroma_stall <= 1'b0;
    end

    // every chroma word taken is compared with the oldest owed one
    always @(posedge clk)
    begin : check_word
        chroma_word_t want;
        if (rst_n && chroma_valid && !chroma_stall)
        begin
            if (pending_chroma.size() == 0)
                report_mismatch("chroma word with none owed, chroma_x", chroma_x, 0);
            else
            begin
                want = pending_chroma.pop_front();
                if (chroma_x !== want.x)
                    report_mismatch("chroma_x", chroma_x, want.x);
                if (chroma_y !== want.y)
                    report_mismatch("chroma_y", chroma_y, want.y);
                if (defined !== want.def)
                    report_mismatch("defined", defined, want.def);
                if (last_out !== want.last)
                    report_mismatch("last_out", last_out, want.last);
                words_checked++;
            end
        end
    end

    initial
    begin
        // every input known from time zero, reset held low at the start
        rst_n           = 1'b0;
        pixel_valid     = 1'b0;
        red             = '0;
        green           = '0;
        blue            = '0;
        end_of_frame    = 1'b0;
        chroma_stall    = 1'b0;
        stall_left      = 0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_pixels();
        test_random_pixels(1200);
        test_drain_pause();
        test_back_to_back();

        // let the pipe empty, then watch for stray words
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d pixels (%0d frame ends), checked %0d chroma words",
                 pixels_sent, frame_ends, words_checked);
        $display("black after truncation: %0d, full-scale wraps: %0d",
                 black_pixels, wrapped_quotients);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #20_000_000;
        $display("timeout with %0d chroma words still owed", pending_chroma.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rgbcie_pkg.sv
src/rgbcie_tristim.sv
src/rgbcie_divide.sv
src/rgb_to_cie_chromaticity.sv
src/rgbcie_checker.sv
test/tb_rgb_to_cie_chromaticity.sv
